>>> rtl/fnu_pkg.sv
// Shared widths and word types for the face normal unit.
package fnu_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int OUT_W            = 16;
    localparam int EDGE_W           = COORD_WIDTH + 1;
    localparam int PROD_W           = 2 * EDGE_W;
    localparam int CROSS_W          = PROD_W + 1;
    localparam int POS_W            = $clog2(CROSS_W);
    localparam int MAG_W            = 30;
    localparam int NORM_TOP         = MAG_W - 1;
    localparam int SQ_W             = 2 * MAG_W;
    localparam int SUM_W            = SQ_W + 2;
    localparam int ROOT_W           = SUM_W / 2;
    localparam int NUM_W            = MAG_W + NORMAL_FRAC_BITS + 1;
    localparam int QUO_W            = 16;
    localparam int REM_W            = NUM_W + 2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] origin_z;
        logic signed [COORD_WIDTH-1:0] last_x;
        logic signed [COORD_WIDTH-1:0] last_y;
        logic signed [COORD_WIDTH-1:0] last_z;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
        logic signed [COORD_WIDTH-1:0] second_z;
    } face_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
    } normal_word_t;

    // Scaled cross product magnitudes, signs and the zero flag.
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  degen;
    } norm_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        norm_t             nrm;
    } root_word_t;

endpackage

>>> rtl/fnu_front.sv
// Edge vectors, cross product, magnitudes and power-of-two scaling.
module fnu_front
    import fnu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  face_word_t in_word,
    output logic       out_valid,
    output norm_t      out_norm
);

    logic                            s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                            s4_valid_reg, s5_valid_reg;
    logic signed [2:0][EDGE_W-1:0]   a_reg, b_reg, a_next, b_next;
    logic signed [5:0][PROD_W-1:0]   p_reg, p_next;
    logic        [2:0][CROSS_W-1:0]  m_reg, m_next, m4_reg;
    logic        [2:0]               neg_reg, neg_next, neg4_reg;
    logic signed [CROSS_W-1:0]       c_tmp [3];
    logic        [CROSS_W-1:0]       or_all;
    logic        [POS_W-1:0]         pos_reg, pos_next;
    logic                            degen_reg, degen_next;
    norm_t                           norm_reg, norm_next;
    logic        [CROSS_W-1:0]       sh_tmp;

    always_comb
    begin
        a_next[0] = EDGE_W'(in_word.last_x) - EDGE_W'(in_word.origin_x);
        a_next[1] = EDGE_W'(in_word.last_y) - EDGE_W'(in_word.origin_y);
        a_next[2] = EDGE_W'(in_word.last_z) - EDGE_W'(in_word.origin_z);
        b_next[0] = EDGE_W'(in_word.second_x) - EDGE_W'(in_word.origin_x);
        b_next[1] = EDGE_W'(in_word.second_y) - EDGE_W'(in_word.origin_y);
        b_next[2] = EDGE_W'(in_word.second_z) - EDGE_W'(in_word.origin_z);
    end

    always_comb
    begin
        p_next[0] = PROD_W'($signed(a_reg[1])) * PROD_W'($signed(b_reg[2]));
        p_next[1] = PROD_W'($signed(a_reg[2])) * PROD_W'($signed(b_reg[1]));
        p_next[2] = PROD_W'($signed(a_reg[2])) * PROD_W'($signed(b_reg[0]));
        p_next[3] = PROD_W'($signed(a_reg[0])) * PROD_W'($signed(b_reg[2]));
        p_next[4] = PROD_W'($signed(a_reg[0])) * PROD_W'($signed(b_reg[1]));
        p_next[5] = PROD_W'($signed(a_reg[1])) * PROD_W'($signed(b_reg[0]));
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_tmp[i]    = CROSS_W'($signed(p_reg[2*i])) - CROSS_W'($signed(p_reg[2*i+1]));
            neg_next[i] = c_tmp[i][CROSS_W-1];
            m_next[i]   = neg_next[i] ? CROSS_W'(-c_tmp[i]) : CROSS_W'(c_tmp[i]);
        end
    end

    // Leading one of the OR is the leading one of the largest magnitude.
    always_comb
    begin
        or_all   = m_reg[0] | m_reg[1] | m_reg[2];
        pos_next = '0;
        for (int i = 0; i < CROSS_W; i++)
        begin
            if (or_all[i])
            begin
                pos_next = POS_W'(i);
            end
        end
        degen_next = (or_all == '0);
    end

    // Shift all three so the largest lands in [2^29, 2^30).
    always_comb
    begin
        norm_next.neg   = neg4_reg;
        norm_next.degen = degen_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (pos_reg >= POS_W'(NORM_TOP))
            begin
                sh_tmp = m4_reg[i] >> (pos_reg - POS_W'(NORM_TOP));
            end
            else
            begin
                sh_tmp = m4_reg[i] << (POS_W'(NORM_TOP) - pos_reg);
            end
            norm_next.mag[i] = sh_tmp[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            p_reg     <= p_next;
            m_reg     <= m_next;
            neg_reg   <= neg_next;
            m4_reg    <= m_reg;
            neg4_reg  <= neg_reg;
            pos_reg   <= pos_next;
            degen_reg <= degen_next;
            norm_reg  <= norm_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_norm  = norm_reg;

endmodule

>>> rtl/fnu_sqrt.sv
// Sum of squares and a pipelined integer square root, one root bit per stage.
module fnu_sqrt
    import fnu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  norm_t      in_norm,
    output logic       out_valid,
    output root_word_t out_word
);

    logic             sq_valid_reg;
    logic [2:0][SQ_W-1:0] sq_reg;
    norm_t            sq_norm_reg;

    logic             v_reg [ROOT_W+1];
    logic [SUM_W-1:0] x_reg [ROOT_W+1];
    logic [SUM_W-1:0] r_reg [ROOT_W+1];
    norm_t            n_reg [ROOT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            v_reg[0]     <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg <= in_valid;
            v_reg[0]     <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= SQ_W'(in_norm.mag[i]) * SQ_W'(in_norm.mag[i]);
            end
            sq_norm_reg <= in_norm;
            x_reg[0]    <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            r_reg[0]    <= '0;
            n_reg[0]    <= sq_norm_reg;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_W - 1 - k));
        logic [SUM_W-1:0] t_next;

        assign t_next = r_reg[k] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k+1] <= n_reg[k];
                if (x_reg[k] >= t_next)
                begin
                    x_reg[k+1] <= x_reg[k] - t_next;
                    r_reg[k+1] <= (r_reg[k] >> 1) + BIT;
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k];
                    r_reg[k+1] <= r_reg[k] >> 1;
                end
            end
        end
    end

    assign out_valid     = v_reg[ROOT_W];
    assign out_word.root = r_reg[ROOT_W][ROOT_W-1:0];
    assign out_word.nrm  = n_reg[ROOT_W];

endmodule

>>> rtl/fnu_div.sv
// Three-lane pipelined restoring divider, rounding, clamp and sign.
module fnu_div
    import fnu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  root_word_t   in_word,
    output logic         out_valid,
    output normal_word_t out_word
);

    localparam logic [QUO_W-1:0] ONE_Q = QUO_W'(1) << NORMAL_FRAC_BITS;

    logic                  v_reg [QUO_W+1];
    logic [2:0][REM_W-1:0] rem_reg [QUO_W+1];
    logic [2:0][QUO_W-1:0] q_reg [QUO_W+1];
    logic [ROOT_W-1:0]     s_reg [QUO_W+1];
    logic [2:0]            neg_reg [QUO_W+1];
    logic                  dg_reg [QUO_W+1];

    logic                  o_valid_reg;
    normal_word_t          o_word_reg, o_word_next;
    logic [QUO_W-1:0]      qc;
    logic [OUT_W-1:0]      comp [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    // Numerator: magnitude scaled to the output fraction plus half the length.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= (REM_W'(in_word.nrm.mag[i]) << NORMAL_FRAC_BITS)
                                 + REM_W'(in_word.root >> 1);
                q_reg[0][i]   <= '0;
            end
            s_reg[0]   <= in_word.root;
            neg_reg[0] <= in_word.nrm.neg;
            dg_reg[0]  <= in_word.nrm.degen;
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_quo
        localparam int J = QUO_W - 1 - k;
        logic [REM_W-1:0] d_next;

        assign d_next = REM_W'(s_reg[k]) << J;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[k+1]   <= s_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                dg_reg[k+1]  <= dg_reg[k];
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[k][i] >= d_next)
                    begin
                        rem_reg[k+1][i] <= rem_reg[k][i] - d_next;
                        q_reg[k+1][i]   <= q_reg[k][i] | (QUO_W'(1) << J);
                    end
                    else
                    begin
                        rem_reg[k+1][i] <= rem_reg[k][i];
                        q_reg[k+1][i]   <= q_reg[k][i];
                    end
                end
            end
        end
    end

    always_comb
    begin
        qc = '0;
        for (int i = 0; i < 3; i++)
        begin
            qc      = (q_reg[QUO_W][i] > ONE_Q) ? ONE_Q : q_reg[QUO_W][i];
            comp[i] = neg_reg[QUO_W][i] ? OUT_W'(-qc) : OUT_W'(qc);
            if (dg_reg[QUO_W])
            begin
                comp[i] = '0;
            end
        end
        o_word_next.normal_x   = comp[0];
        o_word_next.normal_y   = comp[1];
        o_word_next.normal_z   = comp[2];
        o_word_next.degenerate = dg_reg[QUO_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= v_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_word_reg <= o_word_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_word  = o_word_reg;

endmodule

>>> rtl/face_normal_unit.sv
// Top level: unit normal of a polygon face, one face word per cycle unless the output is held.
//
//   channel | direction | handshake                   | word
//   face    | in        | face_valid / face_ready     | face_word_t (three vertices)
//   normal  | out       | normal_valid / normal_ready | normal_word_t (normal, flag)
//
// A face word can enter every cycle while the pipe is not held; its normal passes
// through five front stages, two for the sum of squares, 31 square root stages (one root
// bit each), the divider entry, 16 divider stages (one quotient bit each) and
// the output register. All stages advance together; when the output word is
// held by a low normal_ready the whole pipe holds and face_ready drops.
// Reset clears only the valid bits; no clearing pass is needed.
module face_normal_unit
    import fnu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         face_valid,
    output logic         face_ready,
    input  face_word_t   face,
    output logic         normal_valid,
    input  logic         normal_ready,
    output normal_word_t normal
);

    logic       en;
    logic       front_valid, sqrt_valid;
    norm_t      front_norm;
    root_word_t sqrt_word;

    // Advance unless a finished word is waiting on the output.
    assign en         = !normal_valid || normal_ready;
    assign face_ready = en;

    fnu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (face_valid),
        .in_word   (face),
        .out_valid (front_valid),
        .out_norm  (front_norm)
    );

    fnu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_norm   (front_norm),
        .out_valid (sqrt_valid),
        .out_word  (sqrt_word)
    );

    fnu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .in_word   (sqrt_word),
        .out_valid (normal_valid),
        .out_word  (normal)
    );

endmodule

>>> bench/face_normal_unit_test.sv
// Testbench for face_normal_unit: directed and random face words checked against a predictor.
module face_normal_unit_test
    import fnu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 56;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 800;

    typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_e;

    logic         clk;
    logic         rst_n;
    logic         face_valid;
    logic         face_ready;
    face_word_t   face;
    logic         normal_valid;
    logic         normal_ready;
    normal_word_t normal;

    normal_word_t expected_normals[$];
    int           mismatch_count;
    int           faces_sent;
    int           normals_seen;
    int           degenerate_seen;
    int           idle_cycles;
    phase_e       phase;
    bit           hold_off;

    face_normal_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .face_valid   (face_valid),
        .face_ready   (face_ready),
        .face         (face),
        .normal_valid (normal_valid),
        .normal_ready (normal_ready),
        .normal       (normal)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Edges are 17 bits wide here, so the edge limiting step never applies.
    function automatic normal_word_t face_normal(face_word_t f);
        normal_word_t    res;
        longint          a[3];
        longint          b[3];
        longint          c[3];
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned root;
        longint unsigned q;
        longint unsigned unit;
        logic [15:0]     w[3];
        a[0] = longint'(f.last_x) - longint'(f.origin_x);
        a[1] = longint'(f.last_y) - longint'(f.origin_y);
        a[2] = longint'(f.last_z) - longint'(f.origin_z);
        b[0] = longint'(f.second_x) - longint'(f.origin_x);
        b[1] = longint'(f.second_y) - longint'(f.origin_y);
        b[2] = longint'(f.second_z) - longint'(f.origin_z);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        for (int i = 0; i < 3; i++)
            m[i] = magnitude(c[i]);
        res = '0;
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx == 0)
        begin
            res.degenerate = 1'b1;
            return res;
        end
        while (mx >= (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 29))
        begin
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
            mx = mx << 1;
        end
        sum  = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        root = int_sqrt(sum);
        unit = 64'd1 << NORMAL_FRAC_BITS;
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << NORMAL_FRAC_BITS) + (root >> 1)) / root;
            if (q > unit)
                q = unit;
            w[i] = (c[i] < 0) ? 16'(-q) : 16'(q);
        end
        res.normal_x = w[0];
        res.normal_y = w[1];
        res.normal_z = w[2];
        return res;
    endfunction

    function automatic face_word_t make_face(int ox, int oy, int oz, int lx, int ly, int lz,
                                             int sx, int sy, int sz);
        face_word_t f;
        f.origin_x = 16'(ox); f.origin_y = 16'(oy); f.origin_z = 16'(oz);
        f.last_x   = 16'(lx); f.last_y   = 16'(ly); f.last_z   = 16'(lz);
        f.second_x = 16'(sx); f.second_y = 16'(sy); f.second_z = 16'(sz);
        return f;
    endfunction

    function automatic logic signed [15:0] random_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 15)) - 16'sd8;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(0, 1023)) - 16'sd512;
        endcase
    endfunction

    function automatic face_word_t random_face();
        face_word_t f;
        int mode;
        mode = $urandom_range(0, 3);
        f = {9{16'h0000}};
        f.origin_x = random_coord(mode); f.origin_y = random_coord(mode);
        f.origin_z = random_coord(mode);
        f.last_x = random_coord(mode); f.last_y = random_coord(mode);
        f.last_z = random_coord(mode);
        f.second_x = random_coord(mode); f.second_y = random_coord(mode);
        f.second_z = random_coord(mode);
        // Make some faces collinear: second = origin + 3 * (last - origin) along x.
        if ($urandom_range(0, 9) == 0)
        begin
            f.origin_x = random_coord(1); f.origin_y = random_coord(1);
            f.origin_z = random_coord(1);
            f.last_x = f.origin_x + random_coord(1);
            f.last_y = f.origin_y;
            f.last_z = f.origin_z;
            f.second_x = 16'(f.origin_x + 3 * (f.last_x - f.origin_x));
            f.second_y = f.origin_y;
            f.second_z = f.origin_z;
        end
        return f;
    endfunction

    // Send one face word; valid stays high across back-to-back words.
    task automatic send_face(face_word_t f);
        int idle_pct;
        idle_pct = (phase == PH_BOTH) ? 14 : 69;
        if (phase == PH_SEND_IDLE || phase == PH_BOTH)
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                face_valid <= 1'b0;
                @(posedge clk);
            end
        end
        face_valid <= 1'b1;
        face       <= f;
        @(posedge clk);
        while (!face_ready)
            @(posedge clk);
        expected_normals.push_back(face_normal(f));
        faces_sent++;
    endtask

    task automatic drain_normals();
        face_valid <= 1'b0;
        @(posedge clk);
        while (expected_normals.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls per phase, plus a long hold-off when asked.
    initial
    begin
        int stall;
        normal_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                normal_ready <= 1'b0;
                for (stall = 0; stall < 200; stall++)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            if (phase == PH_RECV_STALL)
                normal_ready <= ($urandom_range(0, 99) >= 69);
            else if (phase == PH_BOTH)
                normal_ready <= ($urandom_range(0, 99) >= 14);
            else
                normal_ready <= 1'b1;
        end
    end

    // Compare each accepted normal word with the oldest expectation.
    always @(posedge clk)
    begin
        normal_word_t want;
        if (rst_n && normal_valid && normal_ready)
        begin
            normals_seen++;
            if (expected_normals.size() == 0)
            begin
                $error("normal word with no expectation: %h", normal);
                mismatch_count++;
            end
            else
            begin
                want = expected_normals.pop_front();
                if (want.degenerate) degenerate_seen++;
                if (normal.normal_x !== want.normal_x)
                begin
                    $error("normal_x expected %0d got %0d", want.normal_x, normal.normal_x);
                    mismatch_count++;
                end
                if (normal.normal_y !== want.normal_y)
                begin
                    $error("normal_y expected %0d got %0d", want.normal_y, normal.normal_y);
                    mismatch_count++;
                end
                if (normal.normal_z !== want.normal_z)
                begin
                    $error("normal_z expected %0d got %0d", want.normal_z, normal.normal_z);
                    mismatch_count++;
                end
                if (normal.degenerate !== want.degenerate)
                begin
                    $error("degenerate expected %0b got %0b", want.degenerate,
                           normal.degenerate);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no word accepted on either side.
    always @(posedge clk)
    begin
        if ((face_valid && face_ready) || (normal_valid && normal_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    typedef struct {
        face_word_t   stim;
        bit           typed;
        normal_word_t want;
    } face_row_t;

    initial
    begin
        face_row_t rows[$];
        face_row_t row;
        normal_word_t pred;
        rst_n          = 1'b0;
        face_valid     = 1'b0;
        face           = '0;
        mismatch_count = 0;
        faces_sent     = 0;
        normals_seen   = 0;
        degenerate_seen = 0;
        idle_cycles    = 0;
        phase          = PH_FREE;
        hold_off       = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Typed rows: axis-aligned faces, all-zero and collinear faces.
        rows.push_back('{make_face(0,0,0, 0,0,0, 0,0,0), 1'b1, '{16'sd0,16'sd0,16'sd0,1'b1}});
        rows.push_back('{make_face(0,0,0, 256,0,0, 0,256,0), 1'b1,
                         '{16'sd0,16'sd0,16'sd16384,1'b0}});
        rows.push_back('{make_face(0,0,0, 0,256,0, 256,0,0), 1'b1,
                         '{16'sd0,16'sd0,-16'sd16384,1'b0}});
        rows.push_back('{make_face(0,0,0, 0,1,0, 0,0,1), 1'b1,
                         '{16'sd16384,16'sd0,16'sd0,1'b0}});
        rows.push_back('{make_face(0,0,0, 0,0,1, 1,0,0), 1'b1,
                         '{16'sd0,16'sd16384,16'sd0,1'b0}});
        rows.push_back('{make_face(5,5,5, 7,7,7, 9,9,9), 1'b1, '{16'sd0,16'sd0,16'sd0,1'b1}});
        rows.push_back('{make_face(-32768,-32768,-32768, 32767,-32768,-32768,
                                   -32768,32767,-32768), 1'b1,
                         '{16'sd0,16'sd0,16'sd16384,1'b0}});
        rows.push_back('{make_face(32767,32767,32767, 32767,32767,32767,
                                   -32768,-32768,-32768), 1'b1, '{16'sd0,16'sd0,16'sd0,1'b1}});
        // Predicted rows: extremes mixed across coordinates, and small faces.
        rows.push_back('{make_face(32767,-32768,32767, -32768,32767,-32768,
                                   32767,32767,-32768), 1'b0, '0});
        rows.push_back('{make_face(-32768,32767,0, 32767,-32768,32767,
                                   0,-32768,-32768), 1'b0, '0});
        rows.push_back('{make_face(1,2,3, 4,6,9, -7,5,-2), 1'b0, '0});
        rows.push_back('{make_face(0,0,0, 1,1,1, 1,1,0), 1'b0, '0});
        rows.push_back('{make_face(-1,-1,-1, 32767,0,-32768, -32768,32767,0), 1'b0, '0});
        rows.push_back('{make_face(0,0,0, 1,0,0, 1,1,0), 1'b0, '0});
        rows.push_back('{make_face(100,-200,300, -400,500,-600, 700,-800,900), 1'b0, '0});
        rows.push_back('{make_face(0,0,0, 3,4,0, 0,0,5), 1'b0, '0});

        foreach (rows[i])
        begin
            row = rows[i];
            if (row.typed)
            begin
                pred = face_normal(row.stim);
                if (pred !== row.want)
                begin
                    $error("directed row %0d: predictor %h table %h", i, pred, row.want);
                    mismatch_count++;
                end
            end
            send_face(row.stim);
        end

        // Random phases with different idling patterns.
        for (int p = 0; p < 4; p++)
        begin
            phase = phase_e'(p);
            for (int n = 0; n < RANDOM_ITEMS / 4; n++)
            begin
                if (p == 0 && n == 20)
                    hold_off = 1'b1;
                send_face(random_face());
            end
            // Pause until every normal has arrived.
            drain_normals();
        end

        phase = PH_FREE;
        repeat (LATENCY + 10) @(posedge clk);
        $display("Covered %0d faces, %0d normals checked, %0d degenerate.",
                 faces_sent, normals_seen, degenerate_seen);
        $display("Phases: free flow, sender gaps, receiver stalls, both, and one long hold-off.");
        if (mismatch_count == 0 && expected_normals.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
